[rtl/mrd_pkg.sv]
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared constants and types of the market record deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

  // stream layout
  localparam int HDR_BYTES  = 8;
  localparam int CAP_BYTES  = 56;
  localparam int CAP_W      = CAP_BYTES * 8;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 8;
  localparam int CARRY_POS  = 4;

  // result field widths
  localparam int RC_W       = 32;

  // defaults
  localparam int         DEF_COUNT_WIDTH = 32;
  localparam logic [7:0] DEF_ORDER_TYPE  = 8'hA0;

  // record kinds
  localparam logic [1:0] KIND_ORDER   = 2'd0;
  localparam logic [1:0] KIND_SKIPPED = 2'd1;
  localparam logic [1:0] KIND_HDRONLY = 2'd2;
  localparam logic [1:0] KIND_FATAL   = 2'd3;

  // control from the framing logic to the capture store
  typedef struct packed {
    logic             wr;     // a byte is taken into the current record
    logic [POS_W-1:0] pos;    // byte position of that byte
    logic             clear;  // record completes with this byte
    logic             carry;  // one-word record: header tail opens next record
  } cap_ctl_t;

endpackage

`default_nettype wire

[rtl/mrd_capture.sv]
// ----------------------------------------------------------------------------
// mrd_capture
// Capture store for the first 56 bytes of the current record.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_capture (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mrd_pkg::cap_ctl_t     ctl,
  input  wire logic [7:0]            wr_byte,
  output logic [mrd_pkg::CAP_W-1:0]  cap_bytes   // store with this byte applied
);
  import mrd_pkg::*;

  logic [7:0] cap_r   [CAP_BYTES];
  logic [7:0] cap_nxt [CAP_BYTES];
  logic [7:0] wr_view [CAP_BYTES];

  always_comb begin
    for (int i = 0; i < CAP_BYTES; i++) begin
      wr_view[i] = (ctl.wr && ctl.pos == POS_W'(i)) ? wr_byte : cap_r[i];
      cap_bytes[i*8 +: 8] = wr_view[i];
    end
  end

  // clear at record end, keeping header bytes 4..7 when they start the next one
  always_comb begin
    for (int i = 0; i < CAP_BYTES; i++) begin
      if (ctl.clear) begin
        cap_nxt[i] = 8'd0;
      end else begin
        cap_nxt[i] = wr_view[i];
      end
    end
    if (ctl.clear && ctl.carry) begin
      for (int i = 0; i < CARRY_POS; i++) begin
        cap_nxt[i] = wr_view[i + CARRY_POS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAP_BYTES; i++) begin
        cap_r[i] <= 8'd0;
      end
    end else begin
      cap_r <= cap_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/market_record_deframer.sv]
// ----------------------------------------------------------------------------
// market_record_deframer
// Length-prefixed record deframer: splits a byte stream into records, counts
// them and reports each one, decoding the payload of the order record type.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | words carried
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_ready  | one stream byte
//  out_    | output    | out_valid/out_ready| one record report, all fields
//  cfg_    | input     | cfg_we (no wait)   | order record type
//
//  one byte is taken per clock while in_ready is high; the report of a record is
//  registered and shows on out_ in the cycle after its last byte is taken
//  in_ready drops only while a report waits in the output register and the
//  next byte would produce another report; bytes that produce none keep flowing
//  synchronous active-low reset clears the framing state, the count, the
//  capture store and the output valid; the order type returns to 0xA0
//  after a zero-length header every byte is taken and dropped until reset
//
`default_nettype none

module market_record_deframer #(
  parameter int COUNT_WIDTH = mrd_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte stream
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  // record reports
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_record_kind,
  output logic [31:0]             out_record_count,
  output logic [31:0]             out_instrument_code,
  output logic [15:0]             out_publisher_code,
  output logic [63:0]             out_event_time,
  output logic [63:0]             out_order_number,
  output logic signed [63:0]      out_scaled_price,
  output logic [31:0]             out_quantity,
  output logic [31:0]             out_misc_bytes,
  output logic [63:0]             out_receive_time,
  output logic signed [31:0]      out_receive_delta,
  output logic [31:0]             out_sequence_number,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  import mrd_pkg::*;

  // framing state
  logic [POS_W-1:0]       pos_r;
  logic [LEN_W-1:0]       len_r;
  logic [7:0]             type_r;
  logic                   halted_r;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [7:0]             order_type_r;

  // output register
  logic                   out_valid_r;
  logic [1:0]             kind_r;
  logic [RC_W-1:0]        count_r;
  logic [31:0]            instr_r;
  logic [15:0]            publ_r;
  logic [63:0]            evt_r, ordno_r, price_r, rxt_r;
  logic [31:0]            qty_r, misc_r, delta_r, seq_r;

  cap_ctl_t               cap_ctl;
  logic [CAP_W-1:0]       cap_bytes;

  logic                   step;        // byte accepted and not dropped
  logic [POS_W-1:0]       pos_inc;
  logic                   at_hdr;      // header complete with this byte
  logic [LEN_W-1:0]       len_eff;
  logic [7:0]             type_eff;
  logic [POS_W-1:0]       rec_len_bytes;
  logic                   fatal, done, emit;
  logic                   is_order, with_payload;
  logic [1:0]             kind;
  logic [RC_W-1:0]        count_rep;

  // framing decisions for the byte at the input; none depends on its value
  assign pos_inc   = pos_r + POS_W'(1);
  assign at_hdr    = (pos_inc == POS_W'(HDR_BYTES));
  // header bytes 0 and 1 are already held when the header completes
  assign len_eff   = at_hdr ? cap_bytes[7:0]  : len_r;
  assign type_eff  = at_hdr ? cap_bytes[15:8] : type_r;
  assign rec_len_bytes = {len_eff, 2'b00};
  assign fatal     = at_hdr && (len_eff == '0);
  assign done      = !fatal && (pos_inc >= POS_W'(HDR_BYTES)) && (pos_inc >= rec_len_bytes);
  assign emit      = !halted_r && (fatal || done);

  // a byte that produces no report never waits on the output side
  assign in_ready  = !out_valid_r || out_ready || !emit;
  assign step      = in_valid && in_ready && !halted_r;

  assign cap_ctl.wr    = step;
  assign cap_ctl.pos   = pos_r;
  assign cap_ctl.clear = step && done;
  assign cap_ctl.carry = (len_eff == LEN_W'(1));

  mrd_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cap_ctl),
    .wr_byte   (in_data_byte),
    .cap_bytes (cap_bytes)
  );

  // saturating record counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (done && !(&cnt_r)) begin
      cnt_nxt = cnt_r + COUNT_WIDTH'(1);
    end
  end

  generate
    if (COUNT_WIDTH > RC_W) begin : g_cnt_sat
      assign count_rep = (|cnt_nxt[COUNT_WIDTH-1:RC_W]) ? '1 : cnt_nxt[RC_W-1:0];
    end else begin : g_cnt_ext
      assign count_rep = RC_W'(cnt_nxt);
    end
  endgenerate

  // report classification
  assign is_order     = (type_eff == order_type_r);
  assign with_payload = done && is_order && (len_eff > LEN_W'(2));

  always_comb begin
    if (fatal) begin
      kind = KIND_FATAL;
    end else if (!is_order) begin
      kind = KIND_SKIPPED;
    end else if (len_eff <= LEN_W'(2)) begin
      kind = KIND_HDRONLY;
    end else begin
      kind = KIND_ORDER;
    end
  end

  // framing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      type_r   <= '0;
      halted_r <= 1'b0;
      cnt_r    <= '0;
    end else if (step) begin
      if (done) begin
        pos_r <= cap_ctl.carry ? POS_W'(CARRY_POS) : '0;
      end else begin
        pos_r <= pos_inc;
      end
      if (at_hdr) begin
        len_r  <= len_eff;
        type_r <= type_eff;
      end
      if (fatal) begin
        halted_r <= 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_type_r <= DEF_ORDER_TYPE;
    end else if (cfg_we) begin
      order_type_r <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload fields are little-endian slices of record bytes 8..55
  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind_r  <= kind;
      count_r <= fatal ? RC_W'(0) | count_rep : count_rep;
      instr_r <= cap_bytes[63:32];
      publ_r  <= cap_bytes[31:16];
      if (with_payload) begin
        evt_r   <= cap_bytes[127:64];
        ordno_r <= cap_bytes[191:128];
        price_r <= cap_bytes[255:192];
        qty_r   <= cap_bytes[287:256];
        misc_r  <= cap_bytes[319:288];
        rxt_r   <= cap_bytes[383:320];
        delta_r <= cap_bytes[415:384];
        seq_r   <= cap_bytes[447:416];
      end else begin
        evt_r   <= '0;
        ordno_r <= '0;
        price_r <= '0;
        qty_r   <= '0;
        misc_r  <= '0;
        rxt_r   <= '0;
        delta_r <= '0;
        seq_r   <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = kind_r;
  assign out_record_count    = count_r;
  assign out_instrument_code = instr_r;
  assign out_publisher_code  = publ_r;
  assign out_event_time      = evt_r;
  assign out_order_number    = ordno_r;
  assign out_scaled_price    = $signed(price_r);
  assign out_quantity        = qty_r;
  assign out_misc_bytes      = misc_r;
  assign out_receive_time    = rxt_r;
  assign out_receive_delta   = $signed(delta_r);
  assign out_sequence_number = seq_r;

endmodule

`default_nettype wire

[rtl/mrd_checker.sv]
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks of the market record deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_record_kind,
  input wire logic [31:0] out_record_count,
  input wire logic [63:0] out_event_time,
  input wire logic [63:0] out_order_number,
  input wire logic [63:0] out_scaled_price,
  input wire logic [31:0] out_quantity,
  input wire logic [31:0] out_sequence_number
);
  import mrd_pkg::*;

  logic fatal_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fatal_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_record_kind == KIND_FATAL) begin
      fatal_seen_r <= 1'b1;
    end
  end

  // a stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_record_kind)
                                && $stable(out_record_count))
    else $error("report changed while stalled");

  // nothing follows a zero-length report
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    fatal_seen_r |-> !out_valid)
    else $error("report after zero-length header");

  // only decoded order records carry payload
  a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != KIND_ORDER |->
      out_event_time == '0 && out_order_number == '0 && out_scaled_price == '0
      && out_quantity == '0 && out_sequence_number == '0)
    else $error("payload on a report without payload");

  // a completed record is always counted
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != KIND_FATAL |-> out_record_count != '0)
    else $error("completed record reported with zero count");

endmodule

bind market_record_deframer mrd_checker u_mrd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_record_kind     (out_record_kind),
  .out_record_count    (out_record_count),
  .out_event_time      (out_event_time),
  .out_order_number    (out_order_number),
  .out_scaled_price    (out_scaled_price),
  .out_quantity        (out_quantity),
  .out_sequence_number (out_sequence_number)
);

`default_nettype wire

[test/market_record_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// market_record_deframer testbench
// Drives length-prefixed byte records into the deframer and checks every
// record report against a cycle-free model of the framing, the capture store
// and the record count. A directed table of records comes first, then random
// records under several order types, and finally a zero-length header that
// halts the block. Both handshakes idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import mrd_pkg::*;

  // payload fill of a record
  typedef enum logic [1:0] {FILL_RANDOM, FILL_CONST, FILL_RAMP} fill_t;

  // one record report, field order as on the out_ ports
  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        count;
    logic [31:0]        instrument;
    logic [15:0]        publisher;
    logic [63:0]        event_time;
    logic [63:0]        order_no;
    logic signed [63:0] price;
    logic [31:0]        qty;
    logic [31:0]        misc;
    logic [63:0]        rx_time;
    logic signed [31:0] rx_delta;
    logic [31:0]        seq_no;
  } report_t;

  // one directed record; kind and count are typed only where typed is set
  typedef struct packed {
    logic [7:0]  len;
    logic [7:0]  typ;
    logic [15:0] pub;
    logic [31:0] inst;
    fill_t       mode;
    logic [7:0]  fill;
    logic        typed;
    logic [1:0]  kind;
    logic [31:0] count;
  } stim_row_t;

  localparam int N_DIR = 18;
  localparam int N_FIELDS = 12;

  // directed records: extremes of the header, every non-fatal kind, short and one-word
  // records, a payload past the capture window and the longest record
  stim_row_t dir_rows [N_DIR] = '{
    // header-only order record straight after reset
    '{8'd2,   8'hA0, 16'h0000, 32'h0000_0000, FILL_CONST,  8'h00, 1'b1, KIND_HDRONLY, 32'd1},
    // full capture window, all ones and all zeros
    '{8'd14,  8'hA0, 16'hFFFF, 32'hFFFF_FFFF, FILL_CONST,  8'hFF, 1'b1, KIND_ORDER,   32'd2},
    '{8'd14,  8'hA0, 16'h1234, 32'h89AB_CDEF, FILL_CONST,  8'h00, 1'b1, KIND_ORDER,   32'd3},
    // short record, the tail of the window reads as zero
    '{8'd3,   8'hA0, 16'h8001, 32'h0000_0001, FILL_CONST,  8'hFF, 1'b0, KIND_ORDER,   32'd0},
    '{8'd5,   8'hA0, 16'h5A5A, 32'h1357_9BDF, FILL_RANDOM, 8'h00, 1'b0, KIND_ORDER,   32'd0},
    // other types are skipped with the payload fields cleared
    '{8'd2,   8'h00, 16'h0001, 32'h8000_0000, FILL_CONST,  8'h00, 1'b1, KIND_SKIPPED, 32'd6},
    '{8'd14,  8'hFF, 16'hFFFF, 32'hFFFF_FFFF, FILL_CONST,  8'hFF, 1'b1, KIND_SKIPPED, 32'd7},
    // one-word records, back to back, header tail opens the next record
    '{8'd1,   8'hA0, 16'h4321, 32'h0000_0000, FILL_CONST,  8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd1,   8'h55, 16'hAAAA, 32'h0000_0000, FILL_CONST,  8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd1,   8'hA0, 16'h0F0F, 32'h0000_0000, FILL_CONST,  8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd6,   8'hA0, 16'hC3C3, 32'h7FFF_FFFF, FILL_RAMP,   8'h00, 1'b0, KIND_ORDER,   32'd0},
    // longest record the length byte allows, then a short skipped one
    '{8'd255, 8'hA0, 16'h7FFF, 32'hDEAD_BEEF, FILL_RANDOM, 8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd3,   8'h11, 16'h0101, 32'h0202_0202, FILL_CONST,  8'hFF, 1'b0, KIND_ORDER,   32'd0},
    // window cut inside the payload and a payload running past it
    '{8'd13,  8'hA0, 16'h2468, 32'h0246_8ACE, FILL_RAMP,   8'h80, 1'b0, KIND_ORDER,   32'd0},
    '{8'd15,  8'hA0, 16'hE00E, 32'hF00F_F00F, FILL_RANDOM, 8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd16,  8'hA0, 16'h9999, 32'h1111_2222, FILL_RANDOM, 8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd2,   8'hA1, 16'h3C3C, 32'h4444_5555, FILL_CONST,  8'h00, 1'b0, KIND_ORDER,   32'd0},
    '{8'd4,   8'hA0, 16'h6E6E, 32'h6666_7777, FILL_RANDOM, 8'h00, 1'b0, KIND_ORDER,   32'd0}
  };

  string field_name [N_FIELDS] = '{"record_kind", "record_count", "instrument_code",
    "publisher_code", "event_time", "order_number", "scaled_price", "quantity",
    "misc_bytes", "receive_time", "receive_delta", "sequence_number"};

  // clock, reset and block ports, all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic in_ready;
  logic out_valid;
  logic [1:0] out_record_kind;
  logic [31:0] out_record_count;
  logic [31:0] out_instrument_code;
  logic [15:0] out_publisher_code;
  logic [63:0] out_event_time;
  logic [63:0] out_order_number;
  logic signed [63:0] out_scaled_price;
  logic [31:0] out_quantity;
  logic [31:0] out_misc_bytes;
  logic [63:0] out_receive_time;
  logic signed [31:0] out_receive_delta;
  logic [31:0] out_sequence_number;

  // deframer model state, reset values
  logic [POS_W-1:0] rec_pos = '0;
  logic [LEN_W-1:0] rec_len_words = '0;
  logic [7:0] rec_type = '0;
  logic [63:0] cap_words [7] = '{default: '0};
  bit halted = 1'b0;
  logic [DEF_COUNT_WIDTH-1:0] records_counted = '0;
  logic [7:0] order_type = DEF_ORDER_TYPE;

  // reports still owed by the block, oldest first
  report_t pending_reports [$];
  int reports_seen = 0;
  int bytes_sent = 0;
  int errors = 0;
  int send_calm = 0;

  market_record_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_record_kind     (out_record_kind),
    .out_record_count    (out_record_count),
    .out_instrument_code (out_instrument_code),
    .out_publisher_code  (out_publisher_code),
    .out_event_time      (out_event_time),
    .out_order_number    (out_order_number),
    .out_scaled_price    (out_scaled_price),
    .out_quantity        (out_quantity),
    .out_misc_bytes      (out_misc_bytes),
    .out_receive_time    (out_receive_time),
    .out_receive_delta   (out_receive_delta),
    .out_sequence_number (out_sequence_number),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (errors < 50) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // report as seen from the capture store; payload only for decoded orders
  function automatic report_t form_report(input logic [1:0] kind, input bit with_payload);
    report_t r;
    r = '0;
    r.kind = kind;
    // count saturates at the 32-bit field maximum whatever the counter width
    r.count = (64'(records_counted) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                      : 32'(records_counted);
    r.instrument = cap_words[0][63:32];
    r.publisher = cap_words[0][31:16];
    if (with_payload) begin
      r.event_time = cap_words[1];
      r.order_no = cap_words[2];
      r.price = cap_words[3];
      r.qty = cap_words[4][31:0];
      r.misc = cap_words[4][63:32];
      r.rx_time = cap_words[5];
      r.rx_delta = cap_words[6][31:0];
      r.seq_no = cap_words[6][63:32];
    end
    return r;
  endfunction

  // advance the deframer by one stream byte; returns 1 when a record reports
  function automatic bit deframe_byte(input logic [7:0] b, output report_t r);
    int unsigned p;
    int unsigned rec_size;
    logic [31:0] carried;
    r = '0;
    if (halted) return 1'b0;
    p = rec_pos;
    // window is cleared at each record start, so each byte lands on zeros
    if (p < CAP_BYTES) cap_words[p >> 3][(p & 7) * 8 +: 8] = b;
    p++;
    rec_pos = p[POS_W-1:0];
    if (p < HDR_BYTES) return 1'b0;
    // header examined once, when its eighth byte is held
    if (p == HDR_BYTES) begin
      rec_len_words = cap_words[0][7:0];
      rec_type = cap_words[0][15:8];
      if (rec_len_words == '0) begin
        halted = 1'b1;
        r = form_report(KIND_FATAL, 1'b0);
        return 1'b1;
      end
    end
    rec_size = rec_len_words * 4;
    if (p < rec_size) return 1'b0;
    if (records_counted != '1) records_counted++;
    if (rec_type != order_type) r = form_report(KIND_SKIPPED, 1'b0);
    else if (rec_size <= HDR_BYTES) r = form_report(KIND_HDRONLY, 1'b0);
    else r = form_report(KIND_ORDER, 1'b1);
    carried = cap_words[0][63:32];
    foreach (cap_words[w]) cap_words[w] = '0;
    // one-word record: the tail of its header is the head of the next one
    if (rec_size < HDR_BYTES) begin
      cap_words[0] = {32'h0, carried};
      rec_pos = POS_W'(HDR_BYTES - rec_size);
    end else begin
      rec_pos = '0;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] field_of(input report_t r, input int k);
    case (k)
      0: return 64'(r.kind);
      1: return 64'(r.count);
      2: return 64'(r.instrument);
      3: return 64'(r.publisher);
      4: return r.event_time;
      5: return r.order_no;
      6: return r.price;
      7: return 64'(r.qty);
      8: return 64'(r.misc);
      9: return r.rx_time;
      10: return 64'(r.rx_delta);
      default: return 64'(r.seq_no);
    endcase
  endfunction

  // idle length: mostly none or short, a few long, now and then a calm run
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 975) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte and hold it until taken; the model steps at the handshake
  task automatic send_byte(input logic [7:0] b, input bit typed, input report_t typed_rep);
    report_t rep;
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (deframe_byte(b, rep)) begin
      pending_reports.insert(pending_reports.size(), typed ? typed_rep : rep);
    end
    bytes_sent++;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a record is exactly 4 * len bytes; a zero length still sends its header
  task automatic send_record(input logic [7:0] len, input logic [7:0] typ,
                             input logic [15:0] pub, input logic [31:0] inst,
                             input fill_t mode, input logic [7:0] fill,
                             input bit typed, input report_t typed_rep);
    logic [63:0] hdr;
    logic [7:0] b;
    int nbytes;
    hdr = {inst, pub, typ, len};
    nbytes = (len == 8'd0) ? HDR_BYTES : 4 * len;
    for (int i = 0; i < nbytes; i++) begin
      if (i < HDR_BYTES) b = hdr[8 * i +: 8];
      else if (mode == FILL_CONST) b = fill;
      else if (mode == FILL_RAMP) b = fill + 8'(i);
      else b = 8'($urandom);
      send_byte(b, typed && (i == nbytes - 1), typed_rep);
    end
  endtask

  // stop offering and wait until every owed report has come out
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // random records, biased to the order type in force and to short lengths;
  // the last one is never a one-word record, so its report is not left owed
  task automatic random_records(input logic [7:0] focus_type, input int byte_budget);
    int bytes_at_start;
    int r;
    logic [7:0] len;
    logic [7:0] typ;
    fill_t mode;
    bytes_at_start = bytes_sent;
    len = 8'd0;
    while (bytes_sent - bytes_at_start < byte_budget || len < 8'd2) begin
      r = $urandom_range(0, 99);
      if (r < 15) len = 8'($urandom_range(1, 2));
      else if (r < 85) len = 8'($urandom_range(3, 16));
      else if (r < 99) len = 8'($urandom_range(17, 32));
      else len = 8'($urandom_range(33, 255));
      typ = ($urandom_range(0, 2) != 0) ? focus_type : 8'($urandom);
      r = $urandom_range(0, 9);
      mode = (r < 8) ? FILL_RANDOM : (r < 9) ? FILL_CONST : FILL_RAMP;
      send_record(len, typ, 16'($urandom), $urandom, mode,
                  ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00, 1'b0, '0);
    end
  endtask

  // report checker: every taken word against the oldest owed report
  always @(posedge clk) begin : check_reports
    report_t got;
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_record_kind, out_record_count, out_instrument_code, out_publisher_code,
             out_event_time, out_order_number, out_scaled_price, out_quantity,
             out_misc_bytes, out_receive_time, out_receive_delta, out_sequence_number};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        flag_error($sformatf("report %0d not expected, kind %0d", reports_seen, got.kind));
      end else begin
        want = pending_reports.pop_front();
        for (int k = 0; k < N_FIELDS; k++)
          if (field_of(got, k) !== field_of(want, k))
            flag_error($sformatf("report %0d %s: got %h expected %h", reports_seen,
                                 field_name[k], field_of(got, k), field_of(want, k)));
      end
    end
  end

  // report side: random back-pressure, plus two long hold-offs so the output
  // register fills and the block has to stall the byte stream
  initial begin : drain_side
    int gap;
    int calm;
    int holds_done;
    calm = 0;
    holds_done = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      @(posedge clk);
      if (holds_done < 2 && reports_seen >= 4 + 8 * holds_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        holds_done++;
      end else begin
        gap = pick_gap(calm);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // byte side: reset, directed table, random phases, then the halting header
  initial begin : stimulus
    report_t typed_rep;
    logic [7:0] phase_type [4];
    phase_type = '{8'h00, 8'hFF, 8'($urandom), DEF_ORDER_TYPE};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed records under the reset order type
    foreach (dir_rows[k]) begin
      typed_rep = '0;
      typed_rep.kind = dir_rows[k].kind;
      typed_rep.count = dir_rows[k].count;
      typed_rep.instrument = dir_rows[k].inst;
      typed_rep.publisher = dir_rows[k].pub;
      // typed order rows fill the whole window with one byte value
      if (dir_rows[k].kind == KIND_ORDER) begin
        typed_rep.event_time = {8{dir_rows[k].fill}};
        typed_rep.order_no = {8{dir_rows[k].fill}};
        typed_rep.price = {8{dir_rows[k].fill}};
        typed_rep.qty = {4{dir_rows[k].fill}};
        typed_rep.misc = {4{dir_rows[k].fill}};
        typed_rep.rx_time = {8{dir_rows[k].fill}};
        typed_rep.rx_delta = {4{dir_rows[k].fill}};
        typed_rep.seq_no = {4{dir_rows[k].fill}};
      end
      send_record(dir_rows[k].len, dir_rows[k].typ, dir_rows[k].pub, dir_rows[k].inst,
                  dir_rows[k].mode, dir_rows[k].fill, dir_rows[k].typed, typed_rep);
    end

    // order type changes only with the block idle at a record boundary;
    // the report is registered in the cycle after its last byte, so a short settle is ample
    foreach (phase_type[p]) begin
      wait_drained(4);
      cfg_wdata <= phase_type[p];
      cfg_we <= 1'b1;
      @(posedge clk);
      cfg_we <= 1'b0;
      order_type = phase_type[p];
      random_records(phase_type[p], 40);
    end

    // zero-length header, sometimes carried in behind a one-word record;
    // every byte after it is swallowed without a report
    if ($urandom_range(0, 1) != 0)
      send_record(8'd1, order_type, 16'($urandom), 32'h0, FILL_RANDOM, 8'h00, 1'b0, '0);
    send_record(8'd0, 8'($urandom), 16'($urandom), $urandom, FILL_RANDOM, 8'h00,
                1'b0, '0);
    repeat (16) send_byte(8'($urandom), 1'b0, '0);

    wait_drained(8);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
